[rtl/core/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked property shorthands for the checker modules.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ARP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ARP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/arp_pkg.sv]
// ---------------------------------------------------------------------------
// ARP cache package
// Widths, protocol constants, item/result words and controller types.
// ---------------------------------------------------------------------------
package arp_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 16;

  localparam int unsigned IP_W    = 32;
  localparam int unsigned MAC_W   = 48;
  localparam int unsigned LEN_W   = 11;
  localparam int unsigned HTYPE_W = 16;
  localparam int unsigned ALEN_W  = 8;
  localparam int unsigned OP_W    = 16;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_IP  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_MAC = 1'd1;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_PACKET = 1'b1;

  localparam logic [LEN_W-1:0]   MIN_ARP_LEN = 11'd28;
  localparam logic [HTYPE_W-1:0] HTYPE_ETH   = 16'h0001;
  localparam logic [HTYPE_W-1:0] PTYPE_IPV4  = 16'h0800;
  localparam logic [ALEN_W-1:0]  HLEN_ETH    = 8'd6;
  localparam logic [ALEN_W-1:0]  PLEN_IPV4   = 8'd4;
  localparam logic [OP_W-1:0]    OP_REQUEST  = 16'd1;
  localparam logic [OP_W-1:0]    OP_REPLY    = 16'd2;

  typedef struct packed {
    logic               cmd;
    logic [LEN_W-1:0]   pkt_len;
    logic [HTYPE_W-1:0] hw_type;
    logic [HTYPE_W-1:0] proto_type;
    logic [ALEN_W-1:0]  hw_addr_len;
    logic [ALEN_W-1:0]  proto_addr_len;
    logic [OP_W-1:0]    opcode;
    logic [MAC_W-1:0]   sender_mac;
    logic [IP_W-1:0]    snd_ip;
    logic [IP_W-1:0]    tgt_ip;
    logic [IP_W-1:0]    query_ip;
  } arp_item_t;

  typedef struct packed {
    logic             lookup_hit;
    logic [MAC_W-1:0] lookup_mac;
    logic             packet_accepted;
    logic             send_reply;
    logic [MAC_W-1:0] reply_dest_mac;
    logic [IP_W-1:0]  reply_dest_ip;
  } arp_result_t;

  typedef struct packed {
    logic load;
    logic scan_en;
    logic learn;
    logic res_load;
  } arp_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic learn_req;
    logic out_free;
  } arp_sts_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LEARN,
    ST_DONE
  } arp_state_t;

endpackage

[rtl/core/arp_in_if.sv]
// ---------------------------------------------------------------------------
// ARP item channel
// Valid/ready channel carrying one decoded lookup or ARP packet word.
// ---------------------------------------------------------------------------
interface arp_in_if;
  logic                             valid;
  logic                             ready;
  logic                             cmd;
  logic [arp_pkg::LEN_W-1:0]        pkt_len;
  logic [arp_pkg::HTYPE_W-1:0]      hw_type;
  logic [arp_pkg::HTYPE_W-1:0]      proto_type;
  logic [arp_pkg::ALEN_W-1:0]       hw_addr_len;
  logic [arp_pkg::ALEN_W-1:0]       proto_addr_len;
  logic [arp_pkg::OP_W-1:0]         opcode;
  logic [arp_pkg::MAC_W-1:0]        sender_mac;
  logic [arp_pkg::IP_W-1:0]         snd_ip;
  logic [arp_pkg::IP_W-1:0]         tgt_ip;
  logic [arp_pkg::IP_W-1:0]         query_ip;

  modport source (
    output valid, cmd, pkt_len, hw_type, proto_type, hw_addr_len, proto_addr_len,
           opcode, sender_mac, snd_ip, tgt_ip, query_ip,
    input  ready
  );

  modport sink (
    input  valid, cmd, pkt_len, hw_type, proto_type, hw_addr_len, proto_addr_len,
           opcode, sender_mac, snd_ip, tgt_ip, query_ip,
    output ready
  );
endinterface

[rtl/core/arp_out_if.sv]
// ---------------------------------------------------------------------------
// ARP result channel
// Valid/ready channel carrying one lookup or packet result word.
// ---------------------------------------------------------------------------
interface arp_out_if;
  logic                        valid;
  logic                        ready;
  logic                        lookup_hit;
  logic [arp_pkg::MAC_W-1:0]   lookup_mac;
  logic                        packet_accepted;
  logic                        send_reply;
  logic [arp_pkg::MAC_W-1:0]   reply_dest_mac;
  logic [arp_pkg::IP_W-1:0]    reply_dest_ip;

  modport source (
    output valid, lookup_hit, lookup_mac, packet_accepted, send_reply,
           reply_dest_mac, reply_dest_ip,
    input  ready
  );

  modport sink (
    input  valid, lookup_hit, lookup_mac, packet_accepted, send_reply,
           reply_dest_mac, reply_dest_ip,
    output ready
  );
endinterface

[rtl/core/arp_cache_responder_unit.sv]
// ---------------------------------------------------------------------------
// ARP cache responder
// Channels: in_if takes one word per item, cmd 0 = lookup of query_ip,
//   cmd 1 = decoded ARP packet; out_if returns exactly one result word per
//   item. cfg_we/cfg_idx/cfg_data write local_ip (0); local_mac (1) is
//   accepted but not stored here; write only while idle.
// Flow: an item is taken in idle, the table is scanned one entry per
//   cycle through the single read port of the entry store, compared on the
//   registered read word; a learned packet adds a write state, and the
//   result is registered. A hit on the key ends the scan early, for
//   lookups and packets alike.
// Items: one at a time; the next is taken once the last result is loaded.
// Reset: valid bits cleared at once, no clearing pass; local_ip = 0.
// Stall: a finished result waits in the output register; the next item is
//   taken and processed, then holds in its last state until the register
//   is free.
// ---------------------------------------------------------------------------
module arp_cache_responder_unit #(
  parameter int unsigned TABLE_ENTRIES = arp_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  arp_in_if.sink                          in_if,
  arp_out_if.source                       out_if,
  input  logic                            cfg_we,
  input  logic [arp_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [arp_pkg::CFG_DATA_W-1:0]  cfg_data
);

  arp_pkg::arp_item_t   item;
  arp_pkg::arp_result_t result;
  arp_pkg::arp_cmd_t    cmd;
  arp_pkg::arp_sts_t    sts;
  logic                 in_rdy;
  logic                 out_vld;

  assign item.cmd            = in_if.cmd;
  assign item.pkt_len        = in_if.pkt_len;
  assign item.hw_type        = in_if.hw_type;
  assign item.proto_type     = in_if.proto_type;
  assign item.hw_addr_len    = in_if.hw_addr_len;
  assign item.proto_addr_len = in_if.proto_addr_len;
  assign item.opcode         = in_if.opcode;
  assign item.sender_mac     = in_if.sender_mac;
  assign item.snd_ip         = in_if.snd_ip;
  assign item.tgt_ip         = in_if.tgt_ip;
  assign item.query_ip       = in_if.query_ip;

  arp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_rdy),
    .sts      (sts),
    .cmd      (cmd)
  );

  arp_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data),
    .item      (item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_vld),
    .out_ready (out_if.ready),
    .result    (result)
  );

  assign in_if.ready            = in_rdy;
  assign out_if.valid           = out_vld;
  assign out_if.lookup_hit      = result.lookup_hit;
  assign out_if.lookup_mac      = result.lookup_mac;
  assign out_if.packet_accepted = result.packet_accepted;
  assign out_if.send_reply      = result.send_reply;
  assign out_if.reply_dest_mac  = result.reply_dest_mac;
  assign out_if.reply_dest_ip   = result.reply_dest_ip;

endmodule

[rtl/core/arp_dp.sv]
// ---------------------------------------------------------------------------
// ARP cache datapath
// Config register, item capture, entry store with a one-entry-per-cycle
// scan, learn write, and the result output register.
// ---------------------------------------------------------------------------
module arp_dp #(
  parameter int unsigned TABLE_ENTRIES = arp_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [arp_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [arp_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  arp_pkg::arp_item_t              item,
  input  arp_pkg::arp_cmd_t               cmd,
  output arp_pkg::arp_sts_t               sts,
  output logic                            out_valid,
  input  logic                            out_ready,
  output arp_pkg::arp_result_t            result
);

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W = IDX_W + 1;
  localparam logic [CNT_W-1:0] LAST = CNT_W'(TABLE_ENTRIES);

  logic [arp_pkg::IP_W-1:0]  local_ip_r;

  logic                      cmd_r;
  logic                      pkt_ok_r;
  logic                      reply_r;
  logic [arp_pkg::IP_W-1:0]  key_ip_r;
  logic [arp_pkg::MAC_W-1:0] key_mac_r;

  logic [CNT_W-1:0]          iss_r;
  logic                      s1_vld_r;
  logic [IDX_W-1:0]          s1_idx_r;
  logic [arp_pkg::IP_W-1:0]  rd_ip_r;
  logic [arp_pkg::MAC_W-1:0] rd_mac_r;

  logic                      hit_r;
  logic [IDX_W-1:0]          hit_idx_r;
  logic [arp_pkg::MAC_W-1:0] hit_mac_r;
  logic                      free_vld_r;
  logic [IDX_W-1:0]          free_idx_r;

  logic                      valid_r [TABLE_ENTRIES];
  logic [arp_pkg::IP_W-1:0]  mem_ip  [TABLE_ENTRIES];
  logic [arp_pkg::MAC_W-1:0] mem_mac [TABLE_ENTRIES];

  logic                      out_valid_r;
  arp_pkg::arp_result_t      res_r;
  arp_pkg::arp_result_t      res_nxt;

  logic                      pkt_ok_in;
  logic                      reply_in;
  logic                      hit_now;
  logic                      free_now;
  logic                      issue;
  logic [IDX_W-1:0]          wr_idx;

  // config; only local_ip is stored, a local_mac write is not kept here
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_ip_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        arp_pkg::REG_LOCAL_IP:  local_ip_r <= cfg_data[arp_pkg::IP_W-1:0];
        arp_pkg::REG_LOCAL_MAC: ;
        default: ;
      endcase
    end
  end

  assign pkt_ok_in = (item.pkt_len >= arp_pkg::MIN_ARP_LEN) &&
                     (item.hw_type == arp_pkg::HTYPE_ETH) &&
                     (item.proto_type == arp_pkg::PTYPE_IPV4) &&
                     (item.hw_addr_len == arp_pkg::HLEN_ETH) &&
                     (item.proto_addr_len == arp_pkg::PLEN_IPV4);
  assign reply_in  = (item.opcode == arp_pkg::OP_REQUEST) && (item.tgt_ip == local_ip_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r     <= item.cmd;
      pkt_ok_r  <= pkt_ok_in;
      reply_r   <= reply_in;
      key_ip_r  <= (item.cmd == arp_pkg::CMD_LOOKUP) ? item.query_ip : item.snd_ip;
      key_mac_r <= item.sender_mac;
    end
  end

  // scan: read issued at iss_r, compared on the registered read word
  assign hit_now  = s1_vld_r && !hit_r && valid_r[s1_idx_r] && (rd_ip_r == key_ip_r);
  assign free_now = s1_vld_r && !free_vld_r && !valid_r[s1_idx_r];
  assign issue    = cmd.scan_en && !hit_r && !hit_now && (iss_r != LAST);
  assign wr_idx   = hit_r ? hit_idx_r : (free_vld_r ? free_idx_r : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_r      <= '0;
      s1_vld_r   <= 1'b0;
      hit_r      <= 1'b0;
      free_vld_r <= 1'b0;
    end else if (cmd.load) begin
      iss_r      <= '0;
      s1_vld_r   <= 1'b0;
      hit_r      <= 1'b0;
      free_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= issue;
      if (issue) begin
        iss_r <= iss_r + 1'b1;
      end
      if (hit_now) begin
        hit_r <= 1'b1;
      end
      if (free_now) begin
        free_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_idx_r <= iss_r[IDX_W-1:0];
    end
    if (hit_now) begin
      hit_idx_r <= s1_idx_r;
      hit_mac_r <= rd_mac_r;
    end
    if (free_now) begin
      free_idx_r <= s1_idx_r;
    end
  end

  // entry store
  always_ff @(posedge clk) begin
    if (cmd.learn) begin
      mem_ip[wr_idx]  <= key_ip_r;
      mem_mac[wr_idx] <= key_mac_r;
    end
    if (issue) begin
      rd_ip_r  <= mem_ip[iss_r[IDX_W-1:0]];
      rd_mac_r <= mem_mac[iss_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        valid_r[i] <= 1'b0;
      end
    end else if (cmd.learn) begin
      valid_r[wr_idx] <= 1'b1;
    end
  end

  // result word
  always_comb begin
    res_nxt = '0;
    if (cmd_r == arp_pkg::CMD_LOOKUP) begin
      res_nxt.lookup_hit = hit_r;
      res_nxt.lookup_mac = hit_r ? hit_mac_r : '0;
    end else if (pkt_ok_r) begin
      res_nxt.packet_accepted = 1'b1;
      res_nxt.send_reply      = reply_r;
      res_nxt.reply_dest_mac  = reply_r ? key_mac_r : '0;
      res_nxt.reply_dest_ip   = reply_r ? key_ip_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_r <= res_nxt;
    end
  end

  assign sts.scan_done = hit_r || ((iss_r == LAST) && !s1_vld_r);
  assign sts.learn_req = (cmd_r == arp_pkg::CMD_PACKET) && pkt_ok_r;
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign result    = res_r;

endmodule

[rtl/core/arp_ctrl.sv]
// ---------------------------------------------------------------------------
// ARP cache controller
// Sequences capture, table scan, learn write and result hand-off.
// ---------------------------------------------------------------------------
module arp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  arp_pkg::arp_sts_t sts,
  output arp_pkg::arp_cmd_t cmd
);

  arp_pkg::arp_state_t state_r;
  arp_pkg::arp_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= arp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      arp_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = arp_pkg::ST_SCAN;
      end
      arp_pkg::ST_SCAN: begin
        if (sts.scan_done) state_nxt = sts.learn_req ? arp_pkg::ST_LEARN : arp_pkg::ST_DONE;
      end
      arp_pkg::ST_LEARN: begin
        state_nxt = arp_pkg::ST_DONE;
      end
      arp_pkg::ST_DONE: begin
        if (sts.out_free) state_nxt = arp_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = arp_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd          = '0;
    case (state_r)
      arp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      arp_pkg::ST_SCAN: begin
        cmd.scan_en = 1'b1;
      end
      arp_pkg::ST_LEARN: begin
        cmd.learn = 1'b1;
      end
      arp_pkg::ST_DONE: begin
        cmd.res_load = sts.out_free;
      end
      default: ;
    endcase
  end

endmodule

[rtl/core/arp_chk.sv]
// ---------------------------------------------------------------------------
// ARP cache port checker
// Port-level checks on result words, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module arp_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       out_lookup_hit,
  input logic [arp_pkg::MAC_W-1:0]  out_lookup_mac,
  input logic                       out_packet_accepted,
  input logic                       out_send_reply,
  input logic [arp_pkg::MAC_W-1:0]  out_reply_dest_mac
);

  `ARP_ASSERT_NOW(a_kind_excl, out_valid && out_lookup_hit, !out_packet_accepted && !out_send_reply, "lookup hit in a packet word")
  `ARP_ASSERT_NOW(a_reply_acc, out_valid && out_send_reply, out_packet_accepted, "reply without accepted packet")
  `ARP_ASSERT_NOW(a_miss_zero, out_valid && !out_lookup_hit, out_lookup_mac == '0, "lookup mac nonzero on miss")
  `ARP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_lookup_mac) && $stable(out_reply_dest_mac), "stalled result word changed")

endmodule

bind arp_cache_responder_unit arp_chk u_arp_chk (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_if.valid),
  .out_ready           (out_if.ready),
  .out_lookup_hit      (out_if.lookup_hit),
  .out_lookup_mac      (out_if.lookup_mac),
  .out_packet_accepted (out_if.packet_accepted),
  .out_send_reply      (out_if.send_reply),
  .out_reply_dest_mac  (out_if.reply_dest_mac)
);

[bench/arp_cache_responder_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP cache responder testbench
// Drives lookup and ARP packet words through the item channel under bursty
// traffic and a stalling result channel, across several station settings.
// Each result word is checked field by field against a fixed expected word or
// an in-bench model of the cache table, the packet filter and reply decision.
// ----------------------------------------------------------------------------
module arp_cache_responder_unit_tb;

  localparam int SLOTS        = arp_pkg::TABLE_ENTRIES_DEF;
  localparam int POOL         = 24;
  localparam int PHASES       = 4;
  localparam int PHASE_WORDS  = 375;
  localparam int MAX_SHOWN    = 10;
  localparam longint WATCHDOG_NS = 5_000_000;
  localparam logic [arp_pkg::IP_W-1:0]  DIRECTED_IP = 32'hC0A8_0001;
  localparam logic [arp_pkg::MAC_W-1:0] MAC_ONES    = 48'hFFFF_FFFF_FFFF;

  typedef struct {
    arp_pkg::arp_item_t   word;
    bit                   fixed;
    arp_pkg::arp_result_t want;
  } probe_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [arp_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [arp_pkg::CFG_DATA_W-1:0] cfg_data;

  arp_in_if  in_ch ();
  arp_out_if out_ch ();

  arp_cache_responder_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_ch),
    .out_if   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  // cache model
  logic                      tbl_valid [SLOTS];
  logic [arp_pkg::IP_W-1:0]  tbl_ip    [SLOTS];
  logic [arp_pkg::MAC_W-1:0] tbl_mac   [SLOTS];
  logic [arp_pkg::IP_W-1:0]  station_ip;
  logic [arp_pkg::MAC_W-1:0] station_mac;

  arp_pkg::arp_result_t     answers_due [$];
  probe_t                   probes [$];
  logic [arp_pkg::IP_W-1:0] ip_pool [POOL];

  int answers_seen;
  int bad_answers;
  int n_lookup, n_hit, n_learn, n_reply, n_reject;
  int burst_left;
  bit valid_low;

  initial begin
    clk = 1'b0;
  end
  always #5 clk = ~clk;

  function automatic arp_pkg::arp_result_t arp_answer(arp_pkg::arp_item_t w);
    arp_pkg::arp_result_t r;
    int slot;
    r = '0;
    slot = -1;
    if (w.cmd == arp_pkg::CMD_LOOKUP) begin
      for (int i = 0; i < SLOTS; i++)
        if (slot < 0 && tbl_valid[i] && tbl_ip[i] == w.query_ip) slot = i;
      if (slot >= 0) begin
        r.lookup_hit = 1'b1;
        r.lookup_mac = tbl_mac[slot];
      end
      return r;
    end
    if (w.pkt_len < arp_pkg::MIN_ARP_LEN || w.hw_type != arp_pkg::HTYPE_ETH ||
        w.proto_type != arp_pkg::PTYPE_IPV4 || w.hw_addr_len != arp_pkg::HLEN_ETH ||
        w.proto_addr_len != arp_pkg::PLEN_IPV4)
      return r;
    for (int i = 0; i < SLOTS; i++)
      if (slot < 0 && tbl_valid[i] && tbl_ip[i] == w.snd_ip) slot = i;
    for (int i = 0; i < SLOTS; i++)
      if (slot < 0 && !tbl_valid[i]) slot = i;
    if (slot < 0) slot = 0;
    tbl_valid[slot] = 1'b1;
    tbl_ip[slot]    = w.snd_ip;
    tbl_mac[slot]   = w.sender_mac;
    r.packet_accepted = 1'b1;
    if (w.opcode == arp_pkg::OP_REQUEST && w.tgt_ip == station_ip) begin
      r.send_reply     = 1'b1;
      r.reply_dest_mac = w.sender_mac;
      r.reply_dest_ip  = w.snd_ip;
    end
    return r;
  endfunction

  function automatic logic [arp_pkg::MAC_W-1:0] rand_mac();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[arp_pkg::MAC_W-1:0];
  endfunction

  function automatic arp_pkg::arp_item_t mk_look(logic [arp_pkg::IP_W-1:0] qip);
    arp_pkg::arp_item_t w;
    w.cmd            = arp_pkg::CMD_LOOKUP;
    w.pkt_len        = arp_pkg::LEN_W'($urandom);
    w.hw_type        = arp_pkg::HTYPE_W'($urandom);
    w.proto_type     = arp_pkg::HTYPE_W'($urandom);
    w.hw_addr_len    = arp_pkg::ALEN_W'($urandom);
    w.proto_addr_len = arp_pkg::ALEN_W'($urandom);
    w.opcode         = arp_pkg::OP_W'($urandom);
    w.sender_mac     = rand_mac();
    w.snd_ip         = $urandom;
    w.tgt_ip         = $urandom;
    w.query_ip       = qip;
    return w;
  endfunction

  function automatic arp_pkg::arp_item_t mk_pkt(logic [arp_pkg::LEN_W-1:0] len,
                                                logic [arp_pkg::HTYPE_W-1:0] ht,
                                                logic [arp_pkg::HTYPE_W-1:0] pt,
                                                logic [arp_pkg::ALEN_W-1:0] hl,
                                                logic [arp_pkg::ALEN_W-1:0] pl,
                                                logic [arp_pkg::OP_W-1:0] op,
                                                logic [arp_pkg::MAC_W-1:0] smac,
                                                logic [arp_pkg::IP_W-1:0] sip,
                                                logic [arp_pkg::IP_W-1:0] tip);
    arp_pkg::arp_item_t w;
    w.cmd            = arp_pkg::CMD_PACKET;
    w.pkt_len        = len;
    w.hw_type        = ht;
    w.proto_type     = pt;
    w.hw_addr_len    = hl;
    w.proto_addr_len = pl;
    w.opcode         = op;
    w.sender_mac     = smac;
    w.snd_ip         = sip;
    w.tgt_ip         = tip;
    w.query_ip       = $urandom;
    return w;
  endfunction

  function automatic arp_pkg::arp_result_t res_of(logic hit,
                                                  logic [arp_pkg::MAC_W-1:0] lmac,
                                                  logic acc, logic rep,
                                                  logic [arp_pkg::MAC_W-1:0] rmac,
                                                  logic [arp_pkg::IP_W-1:0] rip);
    arp_pkg::arp_result_t r;
    r.lookup_hit      = hit;
    r.lookup_mac      = lmac;
    r.packet_accepted = acc;
    r.send_reply      = rep;
    r.reply_dest_mac  = rmac;
    r.reply_dest_ip   = rip;
    return r;
  endfunction

  function automatic logic [arp_pkg::IP_W-1:0] pool_or_any(int any_pct);
    if ($urandom_range(0, 99) < any_pct) return $urandom;
    return ip_pool[$urandom_range(0, POOL-1)];
  endfunction

  // mostly well-formed packets with random content, lookups over the same
  // address pool, and a share of packets with one or all header fields broken
  function automatic arp_pkg::arp_item_t draw_word();
    arp_pkg::arp_item_t w;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) return mk_look(pool_or_any(20));
    w = mk_pkt(arp_pkg::LEN_W'($urandom_range(arp_pkg::MIN_ARP_LEN, 2047)),
               arp_pkg::HTYPE_ETH, arp_pkg::PTYPE_IPV4, arp_pkg::HLEN_ETH,
               arp_pkg::PLEN_IPV4, arp_pkg::OP_REQUEST, rand_mac(), pool_or_any(15),
               pool_or_any(30));
    case ($urandom_range(0, 3))
      0: w.pkt_len = arp_pkg::MIN_ARP_LEN;
      1: w.pkt_len = '1;
      default: ;
    endcase
    case ($urandom_range(0, 9))
      6, 7: w.opcode = arp_pkg::OP_REPLY;
      8, 9: w.opcode = arp_pkg::OP_W'($urandom);
      default: ;
    endcase
    if ($urandom_range(0, 1) == 0) w.tgt_ip = station_ip;
    if (pick >= 85) begin
      case ($urandom_range(0, 5))
        0: w.pkt_len = arp_pkg::LEN_W'($urandom_range(0, arp_pkg::MIN_ARP_LEN - 1));
        1: w.hw_type = arp_pkg::HTYPE_ETH ^ arp_pkg::HTYPE_W'($urandom_range(1, 16'hFFFF));
        2: w.proto_type = arp_pkg::PTYPE_IPV4 ^ arp_pkg::HTYPE_W'($urandom_range(1, 16'hFFFF));
        3: w.hw_addr_len = arp_pkg::HLEN_ETH ^ arp_pkg::ALEN_W'($urandom_range(1, 255));
        4: w.proto_addr_len = arp_pkg::PLEN_IPV4 ^ arp_pkg::ALEN_W'($urandom_range(1, 255));
        default: begin
          w.pkt_len        = arp_pkg::LEN_W'($urandom);
          w.hw_type        = arp_pkg::HTYPE_W'($urandom);
          w.proto_type     = arp_pkg::HTYPE_W'($urandom);
          w.hw_addr_len    = arp_pkg::ALEN_W'($urandom);
          w.proto_addr_len = arp_pkg::ALEN_W'($urandom);
        end
      endcase
    end
    return w;
  endfunction

  task automatic add_probe(arp_pkg::arp_item_t w, bit f, arp_pkg::arp_result_t r);
    probe_t p;
    p.word  = w;
    p.fixed = f;
    p.want  = r;
    probes.push_back(p);
  endtask

  task automatic offer_word(arp_pkg::arp_item_t w, bit fixed, arp_pkg::arp_result_t want);
    arp_pkg::arp_result_t r;
    in_ch.valid          <= 1'b1;
    in_ch.cmd            <= w.cmd;
    in_ch.pkt_len        <= w.pkt_len;
    in_ch.hw_type        <= w.hw_type;
    in_ch.proto_type     <= w.proto_type;
    in_ch.hw_addr_len    <= w.hw_addr_len;
    in_ch.proto_addr_len <= w.proto_addr_len;
    in_ch.opcode         <= w.opcode;
    in_ch.sender_mac     <= w.sender_mac;
    in_ch.snd_ip         <= w.snd_ip;
    in_ch.tgt_ip         <= w.tgt_ip;
    in_ch.query_ip       <= w.query_ip;
    valid_low = 1'b0;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    r = arp_answer(w);
    if (fixed) r = want;
    answers_due.push_back(r);
    if (w.cmd == arp_pkg::CMD_LOOKUP) begin
      n_lookup++;
      if (r.lookup_hit) n_hit++;
    end else if (r.packet_accepted) begin
      n_learn++;
      if (r.send_reply) n_reply++;
    end else begin
      n_reject++;
    end
  endtask

  task automatic sender_pause();
    int gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        valid_low = 1'b1;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    if (!valid_low) begin
      in_ch.valid <= 1'b0;
      valid_low = 1'b1;
    end
    while (answers_due.size() != 0) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  task automatic set_station(logic [arp_pkg::IP_W-1:0] ip, logic [arp_pkg::MAC_W-1:0] mac);
    cfg_we   <= 1'b1;
    cfg_idx  <= arp_pkg::REG_LOCAL_IP;
    cfg_data <= arp_pkg::CFG_DATA_W'(ip);
    @(posedge clk);
    cfg_idx  <= arp_pkg::REG_LOCAL_MAC;
    cfg_data <= mac;
    @(posedge clk);
    cfg_we <= 1'b0;
    station_ip  = ip;
    station_mac = mac;
  endtask

  // result channel: random stall pattern from four modes, two long holds
  initial begin
    int rx_taken;
    int hold_left;
    int mode;
    int cyc;
    bit took;
    rx_taken  = 0;
    hold_left = 0;
    mode      = 0;
    cyc       = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      took = (out_ch.valid === 1'b1 && out_ch.ready === 1'b1);
      if (took) rx_taken++;
      cyc++;
      if (cyc % 64 == 0) mode = $urandom_range(0, 3);
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (took && (rx_taken == 250 || rx_taken == 1000)) begin
        hold_left = 400;
        out_ch.ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= 1'($urandom_range(0, 1));
          2: out_ch.ready <= ($urandom_range(0, 3) == 0);
          default: out_ch.ready <= (cyc % 8 < 5);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    arp_pkg::arp_result_t got;
    arp_pkg::arp_result_t exp_r;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.lookup_hit      = out_ch.lookup_hit;
      got.lookup_mac      = out_ch.lookup_mac;
      got.packet_accepted = out_ch.packet_accepted;
      got.send_reply      = out_ch.send_reply;
      got.reply_dest_mac  = out_ch.reply_dest_mac;
      got.reply_dest_ip   = out_ch.reply_dest_ip;
      answers_seen++;
      if (answers_due.size() == 0) begin
        bad_answers++;
        if (bad_answers <= MAX_SHOWN)
          $display("unexpected result word %0d: hit=%0b acc=%0b rep=%0b", answers_seen,
                   got.lookup_hit, got.packet_accepted, got.send_reply);
      end else begin
        exp_r = answers_due.pop_front();
        if (got.lookup_hit !== exp_r.lookup_hit || got.lookup_mac !== exp_r.lookup_mac ||
            got.packet_accepted !== exp_r.packet_accepted ||
            got.send_reply !== exp_r.send_reply ||
            got.reply_dest_mac !== exp_r.reply_dest_mac ||
            got.reply_dest_ip !== exp_r.reply_dest_ip) begin
          bad_answers++;
          if (bad_answers <= MAX_SHOWN) begin
            $display("result word %0d mismatch at %0t ns", answers_seen, $realtime);
            $display("  exp hit=%0b mac=%012h acc=%0b rep=%0b rmac=%012h rip=%08h",
                     exp_r.lookup_hit, exp_r.lookup_mac, exp_r.packet_accepted,
                     exp_r.send_reply, exp_r.reply_dest_mac, exp_r.reply_dest_ip);
            $display("  got hit=%0b mac=%012h acc=%0b rep=%0b rmac=%012h rip=%08h",
                     got.lookup_hit, got.lookup_mac, got.packet_accepted,
                     got.send_reply, got.reply_dest_mac, got.reply_dest_ip);
          end
        end
      end
    end
  end

  initial begin
    #(WATCHDOG_NS);
    $display("watchdog expired with %0d results outstanding", answers_due.size());
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    logic [arp_pkg::IP_W-1:0]  st_ip  [PHASES];
    logic [arp_pkg::MAC_W-1:0] st_mac [PHASES];
    arp_pkg::arp_item_t w;
    in_ch.valid          <= 1'b0;
    in_ch.cmd            <= arp_pkg::CMD_LOOKUP;
    in_ch.pkt_len        <= '0;
    in_ch.hw_type        <= '0;
    in_ch.proto_type     <= '0;
    in_ch.hw_addr_len    <= '0;
    in_ch.proto_addr_len <= '0;
    in_ch.opcode         <= '0;
    in_ch.sender_mac     <= '0;
    in_ch.snd_ip         <= '0;
    in_ch.tgt_ip         <= '0;
    in_ch.query_ip       <= '0;
    cfg_we   <= 1'b0;
    cfg_idx  <= arp_pkg::REG_LOCAL_IP;
    cfg_data <= '0;
    rst_n    <= 1'b0;
    valid_low    = 1'b1;
    burst_left   = 0;
    answers_seen = 0;
    bad_answers  = 0;
    n_lookup = 0; n_hit = 0; n_learn = 0; n_reply = 0; n_reject = 0;
    station_ip  = '0;
    station_mac = '0;
    for (int i = 0; i < SLOTS; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_ip[i]    = '0;
      tbl_mac[i]   = '0;
    end
    for (int i = 0; i < POOL; i++) ip_pool[i] = $urandom;
    st_ip[0] = DIRECTED_IP;  st_mac[0] = rand_mac();
    st_ip[1] = '0;           st_mac[1] = '0;
    st_ip[2] = '1;           st_mac[2] = MAC_ONES;
    st_ip[3] = ip_pool[3];   st_mac[3] = rand_mac();

    // directed words, local address DIRECTED_IP
    add_probe(mk_look('0), 1'b1, '0);
    add_probe(mk_look('1), 1'b1, '0);
    add_probe(mk_pkt('0, arp_pkg::HTYPE_ETH, arp_pkg::PTYPE_IPV4, arp_pkg::HLEN_ETH,
                     arp_pkg::PLEN_IPV4, arp_pkg::OP_REQUEST,
                     rand_mac(), 32'h0A00_0005, DIRECTED_IP), 1'b1, '0);
    add_probe(mk_pkt(arp_pkg::MIN_ARP_LEN - 1, arp_pkg::HTYPE_ETH, arp_pkg::PTYPE_IPV4,
                     arp_pkg::HLEN_ETH, arp_pkg::PLEN_IPV4, arp_pkg::OP_REQUEST,
                     rand_mac(), 32'h0A00_0005, DIRECTED_IP), 1'b1, '0);
    add_probe(mk_pkt(11'd60, 16'h0000, arp_pkg::PTYPE_IPV4, arp_pkg::HLEN_ETH,
                     arp_pkg::PLEN_IPV4, arp_pkg::OP_REQUEST,
                     rand_mac(), 32'h0A00_0005, DIRECTED_IP), 1'b1, '0);
    add_probe(mk_pkt(11'd60, 16'hFFFF, arp_pkg::PTYPE_IPV4, arp_pkg::HLEN_ETH,
                     arp_pkg::PLEN_IPV4, arp_pkg::OP_REQUEST,
                     rand_mac(), 32'h0A00_0005, DIRECTED_IP), 1'b1, '0);
    add_probe(mk_pkt(11'd60, arp_pkg::HTYPE_ETH, 16'h0806, arp_pkg::HLEN_ETH,
                     arp_pkg::PLEN_IPV4, arp_pkg::OP_REQUEST,
                     rand_mac(), 32'h0A00_0005, DIRECTED_IP), 1'b1, '0);
    add_probe(mk_pkt(11'd60, arp_pkg::HTYPE_ETH, arp_pkg::PTYPE_IPV4, 8'd0,
                     arp_pkg::PLEN_IPV4, arp_pkg::OP_REQUEST,
                     rand_mac(), 32'h0A00_0005, DIRECTED_IP), 1'b1, '0);
    add_probe(mk_pkt(11'd60, arp_pkg::HTYPE_ETH, arp_pkg::PTYPE_IPV4, 8'hFF,
                     arp_pkg::PLEN_IPV4, arp_pkg::OP_REQUEST,
                     rand_mac(), 32'h0A00_0005, DIRECTED_IP), 1'b1, '0);
    add_probe(mk_pkt(11'd60, arp_pkg::HTYPE_ETH, arp_pkg::PTYPE_IPV4, arp_pkg::HLEN_ETH,
                     8'd6, arp_pkg::OP_REQUEST,
                     rand_mac(), 32'h0A00_0005, DIRECTED_IP), 1'b1, '0);
    add_probe(mk_look(32'h0A00_0005), 1'b1, '0);
    add_probe(mk_pkt('1, arp_pkg::HTYPE_ETH, arp_pkg::PTYPE_IPV4, arp_pkg::HLEN_ETH,
                     arp_pkg::PLEN_IPV4, arp_pkg::OP_REQUEST,
                     MAC_ONES, '1, DIRECTED_IP),
              1'b1, res_of(1'b0, '0, 1'b1, 1'b1, MAC_ONES, '1));
    add_probe(mk_look('1), 1'b1, res_of(1'b1, MAC_ONES, 1'b0, 1'b0, '0, '0));
    add_probe(mk_pkt(arp_pkg::MIN_ARP_LEN, arp_pkg::HTYPE_ETH, arp_pkg::PTYPE_IPV4,
                     arp_pkg::HLEN_ETH, arp_pkg::PLEN_IPV4, arp_pkg::OP_REPLY,
                     '0, '0, DIRECTED_IP),
              1'b1, res_of(1'b0, '0, 1'b1, 1'b0, '0, '0));
    add_probe(mk_look('0), 1'b1, res_of(1'b1, '0, 1'b0, 1'b0, '0, '0));
    add_probe(mk_pkt(11'd28, arp_pkg::HTYPE_ETH, arp_pkg::PTYPE_IPV4, arp_pkg::HLEN_ETH,
                     arp_pkg::PLEN_IPV4, arp_pkg::OP_REQUEST,
                     48'h0123_4567_89AB, 32'h0A00_0001, DIRECTED_IP + 1),
              1'b1, res_of(1'b0, '0, 1'b1, 1'b0, '0, '0));
    add_probe(mk_pkt(11'd46, arp_pkg::HTYPE_ETH, arp_pkg::PTYPE_IPV4, arp_pkg::HLEN_ETH,
                     arp_pkg::PLEN_IPV4, 16'hFFFF,
                     rand_mac(), 32'h0A00_0002, DIRECTED_IP), 1'b0, '0);
    add_probe(mk_pkt(11'd46, arp_pkg::HTYPE_ETH, arp_pkg::PTYPE_IPV4, arp_pkg::HLEN_ETH,
                     arp_pkg::PLEN_IPV4, 16'h0000,
                     rand_mac(), 32'h0A00_0003, DIRECTED_IP), 1'b0, '0);
    add_probe(mk_pkt(11'd28, arp_pkg::HTYPE_ETH, arp_pkg::PTYPE_IPV4, arp_pkg::HLEN_ETH,
                     arp_pkg::PLEN_IPV4, arp_pkg::OP_REQUEST,
                     48'h0000_0000_0001, '1, DIRECTED_IP), 1'b0, '0);
    add_probe(mk_look('1), 1'b0, '0);
    add_probe(mk_look(32'h0A00_0001), 1'b0, '0);
    w = mk_pkt('1, '1, '1, '1, '1, '1, MAC_ONES, '1, '1);
    w.cmd = arp_pkg::CMD_LOOKUP;
    w.query_ip = 32'h0A00_0002;
    add_probe(w, 1'b0, '0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int ph = 0; ph < PHASES; ph++) begin
      set_station(st_ip[ph], st_mac[ph]);
      if (ph == 0)
        foreach (probes[i]) begin
          offer_word(probes[i].word, probes[i].fixed, probes[i].want);
          sender_pause();
        end
      for (int n = 0; n < PHASE_WORDS; n++) begin
        offer_word(draw_word(), 1'b0, '0);
        sender_pause();
      end
      drain();
    end

    $display("covered %0d words over %0d station settings: %0d lookups (%0d hits)",
             n_lookup + n_learn + n_reject, PHASES, n_lookup, n_hit);
    $display("  %0d packets learned, %0d answered with a reply, %0d rejected",
             n_learn, n_reply, n_reject);
    if (bad_answers == 0 && answers_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d bad result words, %0d never arrived", bad_answers, answers_due.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/arp_pkg.sv
rtl/core/arp_in_if.sv
rtl/core/arp_out_if.sv
rtl/core/arp_dp.sv
rtl/core/arp_ctrl.sv
rtl/core/arp_cache_responder_unit.sv
rtl/core/arp_chk.sv
bench/arp_cache_responder_unit_tb.sv
